// ----- hw/rtl/gttc_pkg.sv -----
// gttc_pkg: shared types, field widths, calendar tables and reciprocal constants
// for the GPS week/time-of-week to calendar converter. No dependencies.
package gttc_pkg;

    // field widths
    localparam int WEEK_W   = 16;
    localparam int MOW_W    = 30;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLI_W  = 10;

    // internal widths
    localparam int DSS_W   = 19;  // days since 1 Jan 1901, below 487611
    localparam int MSD_W   = 27;  // millisecond of day, below 86400000
    localparam int BLK_W   = 9;   // four-year blocks, up to 333
    localparam int DLEFT_W = 11;  // day within a block, up to 1460
    localparam int YDAY_W  = 9;   // day of year, 1 to 366
    localparam int REMH_W  = 22;  // millisecond of hour
    localparam int REMM_W  = 16;  // millisecond of minute

    // time constants
    localparam int unsigned MS_PER_DAY    = 86400000;
    localparam int unsigned MS_PER_HOUR   = 3600000;
    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int unsigned MOW_MAX       = 604799999;
    localparam int unsigned DAYS_PER_WEEK = 7;

    // calendar constants
    localparam int unsigned MJD_GPS_EPOCH  = 44244;
    localparam int unsigned MJD_JAN1_1901  = 15385;
    localparam int unsigned DAYS_OFFSET    = MJD_GPS_EPOCH - MJD_JAN1_1901;
    localparam int unsigned DAYS_PER_BLOCK = 1461;
    localparam int unsigned DAYS_IN_3_YRS  = 1095;
    localparam int unsigned DAYS_IN_4_YRS  = 1460;
    localparam int unsigned DAYS_PER_YEAR  = 365;
    localparam int unsigned FIRST_YEAR     = 1901;

    // reciprocal multipliers: floor(x * ceil(2^S / d) / 2^S) == floor(x / d)
    // holds exactly as long as d * x_max <= 2^S
    localparam int BLK_SH   = 30;
    localparam int BLK_MW   = 20;
    localparam logic [BLK_MW-1:0] BLK_MUL =
        BLK_MW'(((64'd1 << BLK_SH) + 64'(DAYS_PER_BLOCK) - 64'd1) / 64'(DAYS_PER_BLOCK));
    localparam int BLK_PW   = DSS_W + BLK_MW;

    localparam int HR_SH    = 49;
    localparam int HR_MW    = 28;
    localparam logic [HR_MW-1:0] HR_MUL =
        HR_MW'(((64'd1 << HR_SH) + 64'(MS_PER_HOUR) - 64'd1) / 64'(MS_PER_HOUR));
    localparam int HR_PW    = MSD_W + HR_MW;

    localparam int MIN_SH   = 38;
    localparam int MIN_MW   = 23;
    localparam logic [MIN_MW-1:0] MIN_MUL =
        MIN_MW'(((64'd1 << MIN_SH) + 64'(MS_PER_MINUTE) - 64'd1) / 64'(MS_PER_MINUTE));
    localparam int MIN_PW   = REMH_W + MIN_MW;

    localparam int SEC_SH   = 26;
    localparam int SEC_MW   = 17;
    localparam logic [SEC_MW-1:0] SEC_MUL =
        SEC_MW'(((64'd1 << SEC_SH) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));
    localparam int SEC_PW   = REMM_W + SEC_MW;

    // pipeline geometry
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int BACK_STAGES     = 6;

    // cumulative days before each month
    localparam logic [YDAY_W-1:0] CUM_NORM [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [YDAY_W-1:0] CUM_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // smallest day of year whose month guess, yday * 0.032, reaches k
    localparam logic [YDAY_W-1:0] GUESS_MIN [1:11] = '{
        9'd32, 9'd63, 9'd94, 9'd125, 9'd157, 9'd188,
        9'd219, 9'd250, 9'd282, 9'd313, 9'd344
    };

    typedef struct packed {
        logic [WEEK_W-1:0] gps_week;
        logic [MOW_W-1:0]  millis_of_week;
    } t_in_item;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLI_W-1:0]  millisecond;
    } t_out_item;

    // work item handed from the front to the back
    typedef struct packed {
        logic [DSS_W-1:0] days;
        logic [MSD_W-1:0] ms_of_day;
    } t_work;

    function automatic logic [YDAY_W-1:0] cum_days(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
        return leap ? CUM_LEAP[idx] : CUM_NORM[idx];
    endfunction

endpackage

// ----- hw/rtl/gttc_stream_if.sv -----
// gttc_stream_if: valid/ready channel with a typed payload.
// Payload types come from gttc_pkg at the point of instantiation.
interface gttc_stream_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gps_time_to_calendar_unit.sv -----
// GPS week and time of week to calendar date and time of day.
//
// Channels: i_in (sink) carries gps_week and millis_of_week; o_out (source)
// carries year, month, day, hour, minute, second and millisecond. Both use
// valid/ready; a transfer happens on a rising edge with valid and ready high.
// One result leaves for every input transfer, in order.
//
// Throughput: one item per cycle while o_out.ready is high. Each item passes the
// front register, the queue and six back stages with the output register last.
// The back stages are set by the reciprocal multiplies for the year block,
// hour, minute and second splits.
// Reset (i_rst_n, synchronous, active low) empties the front register, the
// queue and the back pipeline. When the receiver holds o_out.ready low the
// result stays on o_out and the back pipeline holds; the front keeps taking
// items until the queue is full, then drops i_in.ready.
// Dates use a leap year every fourth year (Gregorian only 1901 to 2099).
// Depends on gttc_pkg, gttc_stream_if, gttc_front, gttc_queue, gttc_back.
module gps_time_to_calendar_unit import gttc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gttc_stream_if.sink         i_in,
    gttc_stream_if.source       o_out
);

    logic  w_f_valid;
    logic  w_f_ready;
    t_work w_f_work;
    logic  w_q_valid;
    logic  w_q_ready;
    t_work w_q_work;

    gttc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ready (i_in.ready),
        .o_valid (w_f_valid),
        .o_work  (w_f_work),
        .i_ready (w_f_ready)
    );

    gttc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_work  (w_f_work),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_work  (w_q_work),
        .i_ready (w_q_ready)
    );

    gttc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_work  (w_q_work),
        .o_ready (w_q_ready),
        .o_valid (o_out.valid),
        .o_item  (o_out.data),
        .i_ready (o_out.ready)
    );

endmodule

// ----- hw/rtl/gttc_front.sv -----
// gttc_front: takes input transfers, clamps the time of week and splits it into
// day of week and millisecond of day. Depends on gttc_pkg.
module gttc_front import gttc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    output logic     o_valid,
    output t_work    o_work,
    input  logic     i_ready
);

    logic             w_over;
    logic [2:0]       w_day;
    logic [MOW_W-1:0] w_base;
    t_work            n_work;
    logic             r_vld;
    t_work            r_work;

    always_comb begin
        w_over = i_item.millis_of_week > MOW_W'(MOW_MAX);
        w_day  = '0;
        w_base = '0;
        // clamped values also land on the last day, so the count needs no clamp
        for (int k = 1; k < DAYS_PER_WEEK; k++) begin
            if (i_item.millis_of_week >= MOW_W'(k * MS_PER_DAY)) begin
                w_day  = 3'(k);
                w_base = MOW_W'(k * MS_PER_DAY);
            end
        end
        n_work.ms_of_day = w_over ? MSD_W'(MOW_MAX - 6 * MS_PER_DAY)
                                  : MSD_W'(i_item.millis_of_week - w_base);
        // week * 7 as week * 8 - week
        n_work.days = DSS_W'({i_item.gps_week, 3'b000}) - DSS_W'(i_item.gps_week)
                    + DSS_W'(w_day) + DSS_W'(DAYS_OFFSET);
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ----- hw/rtl/gttc_queue.sv -----
// gttc_queue: small register FIFO of work items between front and back.
// Depends on gttc_pkg.
module gttc_queue import gttc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_ready,
    output logic  o_valid,
    output t_work o_work,
    input  logic  i_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_work  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_cnt = r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ----- hw/rtl/gttc_back.sv -----
// gttc_back: six-stage pipeline from day count and millisecond of day to the
// calendar date and time of day; last stage is the output register. Uses gttc_pkg.
module gttc_back import gttc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_work     i_work,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);

    logic                   w_en;
    logic [BACK_STAGES-1:0] r_vld;

    // stage 1
    logic [DSS_W-1:0]  r1_dss;
    logic [MSD_W-1:0]  r1_msd;
    logic [BLK_PW-1:0] r1_pblk;
    logic [HR_PW-1:0]  r1_phr;
    // stage 2
    logic [BLK_W-1:0]   r2_blocks;
    logic [DLEFT_W-1:0] r2_dleft;
    logic [HOUR_W-1:0]  r2_hour;
    logic [REMH_W-1:0]  r2_remh;
    logic [BLK_W-1:0]   n2_blocks;
    logic [HOUR_W-1:0]  n2_hour;
    // stage 3
    logic [YEAR_W-1:0]  r3_year;
    logic [YDAY_W-1:0]  r3_yday;
    logic [HOUR_W-1:0]  r3_hour;
    logic [REMH_W-1:0]  r3_remh;
    logic [MIN_PW-1:0]  r3_pmin;
    logic [2:0]         n3_q365;
    logic [1:0]         n3_eyears;
    // stage 4
    logic [YEAR_W-1:0]   r4_year;
    logic [MONTH_W-1:0]  r4_month;
    logic [DAY_W-1:0]    r4_day;
    logic [HOUR_W-1:0]   r4_hour;
    logic [MINUTE_W-1:0] r4_minute;
    logic [REMM_W-1:0]   r4_remm;
    logic                n4_leap;
    logic [MONTH_W-1:0]  n4_guess;
    logic                n4_more;
    logic [MONTH_W-1:0]  n4_idx;
    logic [MINUTE_W-1:0] n4_minute;
    // stage 5
    logic [YEAR_W-1:0]   r5_year;
    logic [MONTH_W-1:0]  r5_month;
    logic [DAY_W-1:0]    r5_day;
    logic [HOUR_W-1:0]   r5_hour;
    logic [MINUTE_W-1:0] r5_minute;
    logic [REMM_W-1:0]   r5_remm;
    logic [SEC_PW-1:0]   r5_psec;
    // stage 6
    t_out_item           r6_item;
    logic [SECOND_W-1:0] n6_second;

    // the whole pipe holds while the output register is full and not taken
    assign w_en    = !r_vld[BACK_STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[BACK_STAGES-1];
    assign o_item  = r6_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[BACK_STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        n2_blocks = r1_pblk[BLK_SH +: BLK_W];
        n2_hour   = r1_phr[HR_SH +: HOUR_W];

        n3_q365 = 3'(r2_dleft >= DLEFT_W'(DAYS_PER_YEAR))
                + 3'(r2_dleft >= DLEFT_W'(2 * DAYS_PER_YEAR))
                + 3'(r2_dleft >= DLEFT_W'(DAYS_IN_3_YRS))
                + 3'(r2_dleft >= DLEFT_W'(DAYS_IN_4_YRS));
        // last day of a leap block stays in the fourth year
        n3_eyears = 2'(n3_q365 - 3'(r2_dleft == DLEFT_W'(DAYS_IN_4_YRS)));

        n4_leap  = r3_year[1:0] == 2'b00;
        n4_guess = '0;
        for (int k = 1; k <= 11; k++) begin
            n4_guess = n4_guess + MONTH_W'(r3_yday >= GUESS_MIN[k]);
        end
        n4_more   = r3_yday > cum_days(n4_leap, n4_guess + 4'd1);
        n4_idx    = n4_guess + MONTH_W'(n4_more);
        n4_minute = r3_pmin[MIN_SH +: MINUTE_W];

        n6_second = r5_psec[SEC_SH +: SECOND_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dss  <= i_work.days;
            r1_msd  <= i_work.ms_of_day;
            r1_pblk <= BLK_PW'(i_work.days) * BLK_PW'(BLK_MUL);
            r1_phr  <= HR_PW'(i_work.ms_of_day) * HR_PW'(HR_MUL);

            r2_blocks <= n2_blocks;
            r2_dleft  <= DLEFT_W'(r1_dss - DSS_W'(n2_blocks) * DSS_W'(DAYS_PER_BLOCK));
            r2_hour   <= n2_hour;
            r2_remh   <= REMH_W'(r1_msd - MSD_W'(n2_hour) * MSD_W'(MS_PER_HOUR));

            r3_year <= YEAR_W'(FIRST_YEAR) + YEAR_W'({r2_blocks, 2'b00})
                     + YEAR_W'(n3_eyears);
            r3_yday <= YDAY_W'(r2_dleft - DLEFT_W'(n3_eyears) * DLEFT_W'(DAYS_PER_YEAR)
                     + DLEFT_W'(1));
            r3_hour <= r2_hour;
            r3_remh <= r2_remh;
            r3_pmin <= MIN_PW'(r2_remh) * MIN_PW'(MIN_MUL);

            r4_year   <= r3_year;
            r4_month  <= n4_idx + 4'd1;
            r4_day    <= DAY_W'(r3_yday - cum_days(n4_leap, n4_idx));
            r4_hour   <= r3_hour;
            r4_minute <= n4_minute;
            r4_remm   <= REMM_W'(r3_remh - REMH_W'(n4_minute) * REMH_W'(MS_PER_MINUTE));

            r5_year   <= r4_year;
            r5_month  <= r4_month;
            r5_day    <= r4_day;
            r5_hour   <= r4_hour;
            r5_minute <= r4_minute;
            r5_remm   <= r4_remm;
            r5_psec   <= SEC_PW'(r4_remm) * SEC_PW'(SEC_MUL);

            r6_item.year        <= r5_year;
            r6_item.month       <= r5_month;
            r6_item.day         <= r5_day;
            r6_item.hour        <= r5_hour;
            r6_item.minute      <= r5_minute;
            r6_item.second      <= n6_second;
            r6_item.millisecond <= MILLI_W'(r5_remm - REMM_W'(n6_second)
                                 * REMM_W'(MS_PER_SECOND));
        end
    end

endmodule

// ----- hw/rtl/gttc_checker.sv -----
// gttc_checker: port-level assertions for gps_time_to_calendar_unit, bound to
// the top level. Depends on gttc_pkg.
module gttc_checker import gttc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    localparam int CAP   = 1 + QUEUE_DEPTH + BACK_STAGES;
    localparam int CNT_W = $clog2(CAP + 1) + 1;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic [CNT_W-1:0] r_pending;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    // items taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + CNT_W'(w_in_xfer) - CNT_W'(w_out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("result shown with no item in flight");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(CAP))
        else $error("more items in flight than the pipeline holds");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind gps_time_to_calendar_unit gttc_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_gttc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
